// ===== src/sla_pkg.sv =====
// Shared constants, register codes and the exp2 factor table for the
// spotlight attenuation block. No dependencies.
`default_nettype none

package sla_pkg;

    // Field widths
    localparam int AXIS_W = 32;
    localparam int RAY_W  = 17;
    localparam int EXP_W  = 16;
    localparam int COS_W  = 17;
    localparam int ATT_W  = 16;
    localparam int LEN_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [ATT_W-1:0] ONE_Q15 = 16'h8000;
    localparam logic [30:0]      ONE_Q30 = 31'h4000_0000;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_AXIS_X        = 3'd0,
        REG_AXIS_Y        = 3'd1,
        REG_AXIS_Z        = 3'd2,
        REG_EXPONENT      = 3'd3,
        REG_CONE_EDGE_COS = 3'd4,
        REG_FALLOFF_COS   = 3'd5
    } reg_idx_t;

    // Status of the axis length unit
    typedef struct packed {
        logic             busy;
        logic             zero;
        logic [LEN_W-1:0] len;
    } len_info_t;

    // Q30 factors 2^(-2^-k), k = 1..16
    typedef logic [30:0] exp_tab_t [1:16];

    // Bitwise integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] prev;
        prev = isqrt64(64'd1 << 59);
        t[1] = prev[30:0];
        for (int k = 2; k <= 16; k++)
        begin
            prev = isqrt64({prev[33:0], 30'd0});
            t[k] = prev[30:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== src/sla_if.sv =====
// Handshake channels of the spotlight attenuation block: configuration
// writes, ray words in, attenuation words out. Depends on sla_pkg.
`default_nettype none

interface sla_cfg_if;
    import sla_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [AXIS_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface sla_ray_if;
    import sla_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RAY_W-1:0] ray_dx;
    logic signed [RAY_W-1:0] ray_dy;
    logic signed [RAY_W-1:0] ray_dz;
    modport source (output valid, ray_dx, ray_dy, ray_dz, input ready);
    modport sink (input valid, ray_dx, ray_dy, ray_dz, output ready);
endinterface

interface sla_att_if;
    import sla_pkg::*;
    logic             valid;
    logic             ready;
    logic [ATT_W-1:0] attenuation;
    modport source (output valid, attenuation, input ready);
    modport sink (input valid, attenuation, output ready);
endinterface

`default_nettype wire

// ===== src/sla_len.sv =====
// Axis length unit: sums the three axis squares, then takes a bitwise
// integer square root one result bit per cycle. Depends on sla_pkg.
`default_nettype none

module sla_len (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sla_pkg::AXIS_W-1:0]  ax,
    input  logic signed [sla_pkg::AXIS_W-1:0]  ay,
    input  logic signed [sla_pkg::AXIS_W-1:0]  az,
    output sla_pkg::len_info_t                 info
);
    import sla_pkg::*;

    typedef enum logic [2:0] {
        LS_IDLE = 3'b001,
        LS_SQ   = 3'b010,
        LS_ROOT = 3'b100
    } len_state_t;

    len_state_t        state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [63:0]       sum_reg, sum_next;
    logic [63:0]       v_reg, v_next;
    logic [63:0]       r_reg, r_next;
    logic [63:0]       b_reg, b_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              zero_reg, zero_next;

    logic signed [AXIS_W-1:0] op;
    logic signed [63:0]       sq;
    logic [63:0]              trial;

    // One square per cycle
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    op = ax;
            2'd1:    op = ay;
            default: op = az;
        endcase
        sq    = 64'(op) * 64'(op);
        trial = r_reg + b_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        len_next   = len_reg;
        zero_next  = zero_reg;
        case (state_reg)
            LS_IDLE:
            begin
            end
            LS_SQ:
            begin
                sum_next = sum_reg + sq;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    state_next = LS_ROOT;
                    cnt_next   = 5'd0;
                    v_next     = sum_reg + sq;
                    r_next     = 64'd0;
                    b_next     = 64'h4000_0000_0000_0000;
                end
            end
            LS_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_next = v_reg - trial;
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                b_next   = b_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = LS_IDLE;
                    len_next   = r_next[LEN_W-1:0];
                    zero_next  = (sum_reg == 64'd0);
                end
            end
            default:
            begin
                state_next = LS_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = LS_SQ;
            cnt_next   = 5'd0;
            sum_next   = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
            cnt_reg   <= 5'd0;
            len_reg   <= LEN_W'(32'h0001_0000);
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            zero_reg  <= zero_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        b_reg   <= b_next;
    end

    assign info.busy = (state_reg != LS_IDLE);
    assign info.zero = zero_reg;
    assign info.len  = len_reg;

endmodule

`default_nettype wire

// ===== src/spot_light_attenuation.sv =====
// Top level of the spotlight attenuation block: configuration registers
// and the item pipeline. Depends on sla_pkg, sla_if and sla_len.
//
//   channel  dir  handshake        payload
//   cfg      in   valid / ready    index, data (register write)
//   ray      in   valid / ready    ray_dx, ray_dy, ray_dz
//   res      out  valid / ready    attenuation
//
// One word per cycle while res does not stall and the length unit is not busy.
// The pipe holds the two 15/16-stage restoring dividers and the two
// 16-stage multiply chains of the power (log2 squaring, exp2 products).
// After an axis write, ray.ready stays low while the length unit
// recomputes the axis norm; after reset it is ready at once.
// cfg is always ready.
// A stall at res freezes the whole pipe; nothing is dropped or repeated.
`default_nettype none

module spot_light_attenuation (
    input  logic      clk,
    input  logic      rst_n,
    sla_cfg_if.sink   cfg,
    sla_ray_if.sink   ray,
    sla_att_if.source res
);
    import sla_pkg::*;

    localparam int NST = 54;

    typedef struct packed {
        logic        kill;
        logic        sat;
        logic [46:0] rem;
        logic [14:0] q;
    } dv_t;

    typedef struct packed {
        logic        kill;
        logic        pw_one;
        logic        pw_zero;
        logic [3:0]  msb;
        logic [30:0] m;
        logic [15:0] frac;
        logic        sm_en;
        logic        sm_zero;
        logic        sm_one;
        logic [32:0] srem;
        logic [15:0] p;
    } sq_t;

    typedef struct packed {
        logic        kill;
        logic        pw_one;
        logic        pw_zero;
        logic [27:0] t;
        logic        sm_en;
        logic        sm_zero;
        logic        sm_one;
        logic [30:0] pp;
        logic [16:0] w;
    } tp_t;

    typedef struct packed {
        logic        kill;
        logic        pw_one;
        logic        pw_zero;
        logic        t_zero;
        logic [3:0]  ip;
        logic [15:0] fp;
        logic [30:0] acc;
        logic        sm_en;
        logic        sm_zero;
        logic        sm_one;
        logic [47:0] s;
    } ex_t;

    function automatic logic [3:0] msb15(input logic [14:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            if (v[i])
            begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

    // Configuration registers
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [EXP_W-1:0]         exp_reg;
    logic signed [COS_W-1:0]  cone_reg, fall_reg;
    logic                     len_start;
    len_info_t                len_info;

    assign cfg.ready = 1'b1;
    assign len_start = cfg.valid && (cfg.index == REG_AXIS_X || cfg.index == REG_AXIS_Y
                                     || cfg.index == REG_AXIS_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg   <= '0;
            ay_reg   <= '0;
            az_reg   <= 32'shFFFF_0000;
            exp_reg  <= 16'd256;
            cone_reg <= '0;
            fall_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_AXIS_X:        ax_reg   <= cfg.data;
                REG_AXIS_Y:        ay_reg   <= cfg.data;
                REG_AXIS_Z:        az_reg   <= cfg.data;
                REG_EXPONENT:      exp_reg  <= cfg.data[EXP_W-1:0];
                REG_CONE_EDGE_COS: cone_reg <= cfg.data[COS_W-1:0];
                REG_FALLOFF_COS:   fall_reg <= cfg.data[COS_W-1:0];
                default:           ;
            endcase
        end
    end

    sla_len u_len (
        .clk   (clk),
        .rst_n (rst_n),
        .start (len_start),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .az    (az_reg),
        .info  (len_info)
    );

    // Pipe control: one global advance
    logic             adv;
    logic             take;
    logic [NST-1:0]   vld_reg;
    logic             out_vld_reg;
    logic [ATT_W-1:0] out_att_reg;

    assign adv       = !out_vld_reg || res.ready;
    assign ray.ready = adv && !len_info.busy;
    assign take      = ray.valid && !len_info.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NST-2:0], take};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    // Per-config divisor of the smoothstep
    logic signed [17:0] hi18, lo18, dsm_full;
    logic [16:0]        dsm;
    assign hi18     = 18'(cone_reg);
    assign lo18     = 18'(fall_reg);
    assign dsm_full = hi18 - lo18;
    assign dsm      = dsm_full[16:0];

    // Stage 0: dot product terms
    logic signed [48:0] px_reg, py_reg, pz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 49'(ray.ray_dx) * 49'(ax_reg);
            py_reg <= 49'(ray.ray_dy) * 49'(ay_reg);
            pz_reg <= 49'(ray.ray_dz) * 49'(az_reg);
        end
    end

    // Stage 1: negated sum, zero and sign kills
    logic signed [50:0] n_sum;
    logic               kill1_reg;
    logic [48:0]        num_reg;
    assign n_sum = -(51'(px_reg) + 51'(py_reg) + 51'(pz_reg));
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kill1_reg <= len_info.zero || n_sum[50] || (n_sum == 51'sd0);
            num_reg   <= n_sum[48:0];
        end
    end

    // Stage 2: cosine saturation check, divider entry
    dv_t dv_reg [0:15];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0].kill <= kill1_reg;
            dv_reg[0].sat  <= (num_reg >= {2'b00, len_info.len, 15'd0});
            dv_reg[0].rem  <= num_reg[46:0];
            dv_reg[0].q    <= '0;
        end
    end

    // Stages 3..17: cosine quotient, one bit per stage
    for (genvar j = 0; j < 15; j++)
    begin : g_cdiv
        localparam int K = 14 - j;
        logic [46:0] den;
        logic        ge;
        dv_t         nx;
        always_comb
        begin
            den   = 47'(len_info.len) << K;
            ge    = dv_reg[j].rem >= den;
            nx    = dv_reg[j];
            if (ge)
            begin
                nx.rem = dv_reg[j].rem - den;
            end
            nx.q[K] = ge;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j+1] <= nx;
            end
        end
    end

    // Stage 18: power and smoothstep setup
    sq_t                sq_reg [0:16];
    logic [15:0]        c16;
    logic signed [17:0] cs;
    logic signed [17:0] diff;
    logic [3:0]         msb0;
    logic               below, above, eq;
    always_comb
    begin
        c16   = dv_reg[15].sat ? ONE_Q15 : {1'b0, dv_reg[15].q};
        cs    = signed'({2'b00, c16});
        diff  = cs - lo18;
        below = cs < lo18;
        above = cs > hi18;
        eq    = (hi18 == lo18);
        msb0  = msb15(c16[14:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0].kill    <= dv_reg[15].kill;
            sq_reg[0].pw_one  <= (exp_reg == '0) || (c16 == ONE_Q15);
            sq_reg[0].pw_zero <= (exp_reg != '0) && (c16 == 16'd0);
            sq_reg[0].msb     <= msb0;
            sq_reg[0].m       <= 31'(c16[14:0]) << (5'd30 - 5'(msb0));
            sq_reg[0].frac    <= '0;
            sq_reg[0].sm_en   <= !cone_reg[COS_W-1] && (cone_reg != '0);
            sq_reg[0].sm_zero <= below || (!above && eq);
            sq_reg[0].sm_one  <= !below && above;
            sq_reg[0].srem    <= {1'b0, diff[16:0], 15'd0};
            sq_reg[0].p       <= '0;
        end
    end

    // Stages 19..34: log2 by squaring, and smoothstep quotient
    for (genvar j = 0; j < 16; j++)
    begin : g_sq
        localparam int K = 15 - j;
        logic [61:0] m2;
        logic [31:0] msq;
        logic [32:0] sden;
        logic        ge;
        sq_t         nx;
        always_comb
        begin
            m2   = 62'(sq_reg[j].m) * 62'(sq_reg[j].m);
            msq  = m2[61:30];
            sden = 33'(dsm) << K;
            ge   = sq_reg[j].srem >= sden;
            nx   = sq_reg[j];
            if (msq[31])
            begin
                nx.m       = msq[31:1];
                nx.frac[K] = 1'b1;
            end
            else
            begin
                nx.m = msq[30:0];
            end
            if (ge)
            begin
                nx.srem = sq_reg[j].srem - sden;
            end
            nx.p[K] = ge;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[j+1] <= nx;
            end
        end
    end

    // Stage 35: scaled exponent, smoothstep square
    tp_t         tp_reg;
    logic [19:0] negl;
    logic [35:0] tprod;
    logic [35:0] tsum;
    always_comb
    begin
        negl  = {4'd15 - sq_reg[16].msb, 16'd0} - {4'd0, sq_reg[16].frac};
        tprod = 36'(negl) * 36'(exp_reg);
        tsum  = (tprod + 36'd128) >> 8;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tp_reg.kill    <= sq_reg[16].kill;
            tp_reg.pw_one  <= sq_reg[16].pw_one;
            tp_reg.pw_zero <= sq_reg[16].pw_zero;
            tp_reg.t       <= tsum[27:0];
            tp_reg.sm_en   <= sq_reg[16].sm_en;
            tp_reg.sm_zero <= sq_reg[16].sm_zero;
            tp_reg.sm_one  <= sq_reg[16].sm_one;
            tp_reg.pp      <= 31'(32'(sq_reg[16].p) * 32'(sq_reg[16].p));
            tp_reg.w       <= 17'd98304 - {sq_reg[16].p, 1'b0};
        end
    end

    // Stage 36: split exponent, cubic term
    ex_t ex_reg [0:16];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg[0].kill    <= tp_reg.kill;
            ex_reg[0].pw_one  <= tp_reg.pw_one;
            ex_reg[0].pw_zero <= tp_reg.pw_zero;
            ex_reg[0].t_zero  <= |tp_reg.t[27:20];
            ex_reg[0].ip      <= tp_reg.t[19:16];
            ex_reg[0].fp      <= tp_reg.t[15:0];
            ex_reg[0].acc     <= ONE_Q30;
            ex_reg[0].sm_en   <= tp_reg.sm_en;
            ex_reg[0].sm_zero <= tp_reg.sm_zero;
            ex_reg[0].sm_one  <= tp_reg.sm_one;
            ex_reg[0].s       <= 48'(tp_reg.w) * 48'(tp_reg.pp);
        end
    end

    // Stages 37..52: exp2 of the fraction, one factor per stage
    for (genvar j = 0; j < 16; j++)
    begin : g_exp
        localparam int K = 15 - j;
        logic [61:0] prod;
        ex_t         nx;
        always_comb
        begin
            prod = 62'(ex_reg[j].acc) * 62'(EXP_TAB[j+1]);
            nx   = ex_reg[j];
            if (ex_reg[j].fp[K])
            begin
                nx.acc = prod[60:30];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_reg[j+1] <= nx;
            end
        end
    end

    // Stage 53: integer shift of the power, smoothstep rounding
    logic [4:0]       sh;
    logic [31:0]      rnd;
    logic [31:0]      pw32;
    logic [47:0]      s_rnd;
    logic [ATT_W-1:0] att_sel, smv_sel;
    logic [ATT_W-1:0] att_reg, smv_reg;
    logic             fen_reg, fkill_reg;
    always_comb
    begin
        sh    = 5'd15 + 5'(ex_reg[16].ip);
        rnd   = 32'(ex_reg[16].acc) + (32'd1 << (sh - 5'd1));
        pw32  = rnd >> sh;
        s_rnd = (ex_reg[16].s + 48'h2000_0000) >> 30;
        if (ex_reg[16].pw_one)
        begin
            att_sel = ONE_Q15;
        end
        else if (ex_reg[16].pw_zero || ex_reg[16].t_zero)
        begin
            att_sel = '0;
        end
        else
        begin
            att_sel = pw32[ATT_W-1:0];
        end
        if (ex_reg[16].sm_zero)
        begin
            smv_sel = '0;
        end
        else if (ex_reg[16].sm_one)
        begin
            smv_sel = ONE_Q15;
        end
        else
        begin
            smv_sel = s_rnd[ATT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            att_reg   <= att_sel;
            smv_reg   <= smv_sel;
            fen_reg   <= ex_reg[16].sm_en;
            fkill_reg <= ex_reg[16].kill;
        end
    end

    // Output register: smoothstep product and saturation
    logic [31:0]      fprod;
    logic [31:0]      fsum;
    logic [ATT_W-1:0] fval;
    always_comb
    begin
        fprod = 32'(att_reg) * 32'(smv_reg);
        fsum  = (fprod + 32'd16384) >> 15;
        if (fkill_reg)
        begin
            fval = '0;
        end
        else if (fen_reg)
        begin
            fval = (fsum > 32'(ONE_Q15)) ? ONE_Q15 : fsum[ATT_W-1:0];
        end
        else
        begin
            fval = (att_reg > ONE_Q15) ? ONE_Q15 : att_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_att_reg <= fval;
        end
    end

    assign res.valid       = out_vld_reg;
    assign res.attenuation = out_att_reg;

endmodule

`default_nettype wire
